// ===== rtl/arp_pkg.sv =====
// Shared types, limits and state codes for the AT response parser.
package arp_pkg;

  // Response limits; the counter widths below are sized to hold them.
  localparam int MAX_LINES    = 8;
  localparam int MAX_LINE_LEN = 128;

  localparam int CNT_W = 4;  // line counter, holds MAX_LINES
  localparam int LEN_W = 8;  // line length, holds MAX_LINE_LEN
  localparam int ST_W  = 5;

  localparam logic [CNT_W-1:0] LINES_LIMIT = CNT_W'(MAX_LINES);
  localparam logic [LEN_W-1:0] LEN_LIMIT   = LEN_W'(MAX_LINE_LEN);

  // Character codes.
  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_LF   = 8'd10;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_LO   = 8'd32;   // first printable
  localparam logic [7:0] CH_HI   = 8'd126;  // last printable

  // Parser state codes.
  localparam logic [ST_W-1:0] ST_IDLE    = 5'd0;
  localparam logic [ST_W-1:0] ST_LF1     = 5'd1;
  localparam logic [ST_W-1:0] ST_FIRST   = 5'd2;
  localparam logic [ST_W-1:0] ST_OK_K    = 5'd3;
  localparam logic [ST_W-1:0] ST_OK_CR   = 5'd4;
  localparam logic [ST_W-1:0] ST_OK_LF   = 5'd5;
  localparam logic [ST_W-1:0] ST_E_R1    = 5'd7;
  localparam logic [ST_W-1:0] ST_E_R2    = 5'd8;
  localparam logic [ST_W-1:0] ST_E_O     = 5'd9;
  localparam logic [ST_W-1:0] ST_E_R3    = 5'd10;
  localparam logic [ST_W-1:0] ST_E_CR    = 5'd11;
  localparam logic [ST_W-1:0] ST_E_LF    = 5'd12;
  localparam logic [ST_W-1:0] ST_TEXT    = 5'd14;
  localparam logic [ST_W-1:0] ST_TEXT_LF = 5'd15;
  localparam logic [ST_W-1:0] ST_NEXT    = 5'd16;
  localparam logic [ST_W-1:0] ST_FIN_LF  = 5'd17;
  localparam logic [ST_W-1:0] ST_FIN     = 5'd18;

  // Result status codes.
  localparam logic [1:0] STATUS_BUSY  = 2'd0;
  localparam logic [1:0] STATUS_DONE  = 2'd1;
  localparam logic [1:0] STATUS_FAULT = 2'd2;

  // Parser context carried from byte to byte.
  typedef struct packed {
    logic [ST_W-1:0]  pstate;
    logic [LEN_W-1:0] cur_length;
    logic [CNT_W-1:0] line_counter;
  } arp_ctx_t;

  // One result item.
  typedef struct packed {
    logic [1:0] status;
    logic [3:0] line_total;
    logic       char_valid;
    logic [7:0] char_value;
    logic [2:0] char_line;
    logic [6:0] char_col;
    logic       line_done;
    logic [7:0] line_length;
  } arp_result_t;

endpackage

// ===== rtl/at_response_parser_top.sv =====
// Top level of the AT response parser: input register, parse step, result register.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-------------------------------------------
//   input     | in_valid / in_ready  | byte_value
//   result    | out_valid / out_ready| status, line_total, char_*, line_done,
//             |                      | line_length
//   config    | cfg_write            | cfg_data (special_mode)
//
// Each byte passes through the input register, then the parse step runs and the result
// register loads. One byte per cycle is sustained while the result side does not stall;
// the parser context updates as the result register loads.
// A stall on the result side holds both registers; the input register still
// takes a byte while it is empty. Reset clears the context, mode and valid flags.
module at_response_parser_top
  import arp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [3:0] line_total,
  output logic       char_valid,
  output logic [7:0] char_value,
  output logic [2:0] char_line,
  output logic [6:0] char_col,
  output logic       line_done,
  output logic [7:0] line_length
);

  logic        special_mode;
  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        advance;
  arp_ctx_t    ctx;
  arp_ctx_t    ctx_next;
  arp_result_t step_result;
  arp_result_t result;

  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      special_mode <= 1'b0;
    end else if (cfg_write) begin
      special_mode <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte <= byte_value;
    end
  end

  // Parse step.
  arp_step u_step (
    .ctx          (ctx),
    .byte_value   (hold_byte),
    .special_mode (special_mode),
    .ctx_next     (ctx_next),
    .result       (step_result)
  );

  // Parser context advances with each byte that moves to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx <= '{pstate: ST_IDLE, cur_length: '0, line_counter: '0};
    end else if (advance) begin
      ctx <= ctx_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  assign status      = result.status;
  assign line_total  = result.line_total;
  assign char_valid  = result.char_valid;
  assign char_value  = result.char_value;
  assign char_line   = result.char_line;
  assign char_col    = result.char_col;
  assign line_done   = result.line_done;
  assign line_length = result.line_length;

endmodule

// ===== rtl/arp_step.sv =====
// Combinational per-byte parse step: next context and result for one byte.
module arp_step
  import arp_pkg::*;
(
  input  arp_ctx_t    ctx,
  input  logic [7:0]  byte_value,
  input  logic        special_mode,
  output arp_ctx_t    ctx_next,
  output arp_result_t result
);

  logic       printable;
  logic       lines_full;
  logic       fault;
  logic       done;
  logic       capture;
  logic [ST_W-1:0] ns;

  assign printable  = (byte_value >= CH_LO) && (byte_value <= CH_HI);
  assign lines_full = (ctx.line_counter >= LINES_LIMIT);

  // State transition and result selection.
  always_comb begin
    ns       = ctx.pstate;
    fault    = 1'b0;
    done     = 1'b0;
    capture  = 1'b0;
    ctx_next = ctx;
    result   = '0;
    result.line_total = ctx.line_counter;

    case (ctx.pstate)
      ST_IDLE: begin
        if (byte_value == CH_CR) ns = ST_LF1; else fault = 1'b1;
      end
      ST_LF1: begin
        if (byte_value == CH_LF) ns = special_mode ? ST_TEXT : ST_FIRST;
        else fault = 1'b1;
      end
      ST_FIRST: begin
        if (byte_value == CH_O) ns = ST_OK_K;
        else if (byte_value == CH_E) ns = ST_E_R1;
        else if (byte_value == CH_PLUS) ns = ST_TEXT;
        else fault = 1'b1;
      end
      ST_OK_K: begin
        if (byte_value == CH_K) ns = ST_OK_CR; else fault = 1'b1;
      end
      ST_OK_CR: begin
        if (byte_value == CH_CR) ns = ST_OK_LF; else fault = 1'b1;
      end
      ST_OK_LF: begin
        if (byte_value == CH_LF) done = 1'b1; else fault = 1'b1;
      end
      ST_E_R1: begin
        if (byte_value == CH_R) ns = ST_E_R2; else fault = 1'b1;
      end
      ST_E_R2: begin
        if (byte_value == CH_R) ns = ST_E_O; else fault = 1'b1;
      end
      ST_E_O: begin
        if (byte_value == CH_O) ns = ST_E_R3; else fault = 1'b1;
      end
      ST_E_R3: begin
        if (byte_value == CH_R) ns = ST_E_CR; else fault = 1'b1;
      end
      ST_E_CR: begin
        if (byte_value == CH_CR) ns = ST_E_LF; else fault = 1'b1;
      end
      ST_E_LF: begin
        if (byte_value == CH_LF) done = 1'b1; else fault = 1'b1;
      end
      ST_TEXT: begin
        if (lines_full) fault = 1'b1;
        else if (printable) capture = 1'b1;
        else if (byte_value == CH_CR) ns = ST_TEXT_LF;
        else fault = 1'b1;
      end
      ST_TEXT_LF: begin
        // Line end: report the length and count the line.
        if (byte_value == CH_LF && !lines_full) begin
          result.line_done     = 1'b1;
          result.line_length   = ctx.cur_length;
          ctx_next.line_counter = ctx.line_counter + CNT_W'(1);
          result.line_total    = ctx.line_counter + CNT_W'(1);
          ctx_next.cur_length  = '0;
          ns = ST_NEXT;
        end else begin
          fault = 1'b1;
        end
      end
      ST_NEXT: begin
        if (byte_value == CH_CR) ns = ST_FIN_LF;
        else if (!special_mode && byte_value == CH_PLUS) ns = ST_TEXT;
        else if (special_mode && printable && !lines_full) begin
          ns = ST_TEXT;
          capture = 1'b1;
        end else begin
          fault = 1'b1;
        end
      end
      ST_FIN_LF: begin
        if (byte_value == CH_LF) ns = ST_FIN; else fault = 1'b1;
      end
      ST_FIN: begin
        if (byte_value == CH_E) ns = ST_E_R1;
        else if (byte_value == CH_O) ns = ST_OK_K;
        else fault = 1'b1;
      end
      default: begin
        fault = 1'b1;
      end
    endcase

    // Character capture, with the line length limit.
    if (capture) begin
      if (ctx.cur_length >= LEN_LIMIT) begin
        fault = 1'b1;
      end else begin
        result.char_valid   = 1'b1;
        result.char_value   = byte_value;
        result.char_line    = ctx.line_counter[2:0];
        result.char_col     = ctx.cur_length[6:0];
        ctx_next.cur_length = ctx.cur_length + LEN_W'(1);
        ns = ST_TEXT;
      end
    end

    // Faults clear the per-byte report; faults and completion return to idle.
    if (fault) begin
      result.status      = STATUS_FAULT;
      result.char_valid  = 1'b0;
      result.char_value  = '0;
      result.char_line   = '0;
      result.char_col    = '0;
      result.line_done   = 1'b0;
      result.line_length = '0;
    end else if (done) begin
      result.status = STATUS_DONE;
    end
    if (fault || done) begin
      ns = ST_IDLE;
      ctx_next.cur_length   = '0;
      ctx_next.line_counter = '0;
    end
    ctx_next.pstate = ns;
  end

endmodule

// ===== bench/at_response_parser_top_tb.sv =====
// Self-checking testbench for the AT response parser: random byte streams against a predictor.
module at_response_parser_top_tb;
  import arp_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_BYTES   = 125;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] byte_value = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] status;
  logic [3:0] line_total;
  logic       char_valid;
  logic [7:0] char_value;
  logic [2:0] char_line;
  logic [6:0] char_col;
  logic       line_done;
  logic [7:0] line_length;

  // Bytes waiting to be sent and results predicted for bytes already transferred.
  logic [7:0]  pending_bytes[$];
  arp_result_t predicted_rsp[$];
  int          bytes_queued = 0;

  // Parser copy kept by the predictor, plus the mode the block was last given.
  logic [ST_W-1:0]  prs_state = ST_IDLE;
  logic [LEN_W-1:0] prs_len = '0;
  logic [CNT_W-1:0] prs_lines = '0;
  logic             special_on = 1'b0;

  int  mismatch_count = 0;
  int  results_seen = 0;
  int  send_gap = 0;
  int  hold_left = 0;
  bit  send_calm = 1'b0;
  bit  recv_calm = 1'b0;
  int  quiet_cycles = 0;

  // Opening byte sequence: extreme byte values, a text line ended by DEL, then OK and ERROR.
  logic [7:0] opening_bytes [0:22] = '{
    8'h00, 8'hFF,
    CH_CR, CH_LF, CH_PLUS, 8'd32, 8'd126, 8'd127,
    CH_CR, CH_LF, CH_O, CH_K, CH_CR, CH_LF,
    CH_CR, CH_LF, CH_E, CH_R, CH_R, CH_O, CH_R, CH_CR, CH_LF
  };

  at_response_parser_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .byte_value(byte_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .line_total(line_total),
    .char_valid(char_valid),
    .char_value(char_value),
    .char_line(char_line),
    .char_col(char_col),
    .line_done(line_done),
    .line_length(line_length)
  );

  always #5 clk = ~clk;

  function automatic bit is_printable(logic [7:0] c);
    return c >= CH_LO && c <= CH_HI;
  endfunction

  // Advance the parser copy by one byte and return the result it should produce.
  function automatic arp_result_t parse_byte(logic [7:0] c);
    arp_result_t     r;
    logic [ST_W-1:0] nxt;
    logic [3:0]      total;
    bit              fault;
    bit              fin;
    bit              grab;
    r = '0;
    r.line_total = prs_lines;
    nxt = prs_state;
    fault = 1'b0;
    fin = 1'b0;
    grab = 1'b0;
    case (prs_state)
      ST_IDLE:   if (c == CH_CR) nxt = ST_LF1; else fault = 1'b1;
      ST_LF1:    if (c == CH_LF) nxt = special_on ? ST_TEXT : ST_FIRST; else fault = 1'b1;
      ST_FIRST: begin
        if (c == CH_O) nxt = ST_OK_K;
        else if (c == CH_E) nxt = ST_E_R1;
        else if (c == CH_PLUS) nxt = ST_TEXT;
        else fault = 1'b1;
      end
      ST_OK_K:   if (c == CH_K) nxt = ST_OK_CR; else fault = 1'b1;
      ST_OK_CR:  if (c == CH_CR) nxt = ST_OK_LF; else fault = 1'b1;
      ST_OK_LF:  if (c == CH_LF) fin = 1'b1; else fault = 1'b1;
      ST_E_R1:   if (c == CH_R) nxt = ST_E_R2; else fault = 1'b1;
      ST_E_R2:   if (c == CH_R) nxt = ST_E_O; else fault = 1'b1;
      ST_E_O:    if (c == CH_O) nxt = ST_E_R3; else fault = 1'b1;
      ST_E_R3:   if (c == CH_R) nxt = ST_E_CR; else fault = 1'b1;
      ST_E_CR:   if (c == CH_CR) nxt = ST_E_LF; else fault = 1'b1;
      ST_E_LF:   if (c == CH_LF) fin = 1'b1; else fault = 1'b1;
      ST_TEXT: begin
        if (prs_lines >= LINES_LIMIT) fault = 1'b1;
        else if (is_printable(c)) grab = 1'b1;
        else if (c == CH_CR) nxt = ST_TEXT_LF;
        else fault = 1'b1;
      end
      ST_TEXT_LF: begin
        if (c == CH_LF && prs_lines < LINES_LIMIT) begin
          r.line_done = 1'b1;
          r.line_length = prs_len;
          prs_lines = prs_lines + CNT_W'(1);
          r.line_total = prs_lines;
          prs_len = '0;
          nxt = ST_NEXT;
        end else begin
          fault = 1'b1;
        end
      end
      ST_NEXT: begin
        if (c == CH_CR) nxt = ST_FIN_LF;
        else if (!special_on && c == CH_PLUS) nxt = ST_TEXT;
        else if (special_on && is_printable(c) && prs_lines < LINES_LIMIT) begin
          nxt = ST_TEXT;
          grab = 1'b1;
        end else fault = 1'b1;
      end
      ST_FIN_LF: if (c == CH_LF) nxt = ST_FIN; else fault = 1'b1;
      ST_FIN: begin
        if (c == CH_E) nxt = ST_E_R1;
        else if (c == CH_O) nxt = ST_OK_K;
        else fault = 1'b1;
      end
      default:   fault = 1'b1;
    endcase

    // A captured character lands at the current column unless the line is already full.
    if (grab) begin
      if (prs_len >= LEN_LIMIT) begin
        fault = 1'b1;
      end else begin
        r.char_valid = 1'b1;
        r.char_value = c;
        r.char_line = prs_lines[2:0];
        r.char_col = prs_len[6:0];
        prs_len = prs_len + LEN_W'(1);
        nxt = ST_TEXT;
      end
    end

    // A fault keeps only the line total; a fault or completion returns to idle.
    if (fault) begin
      total = r.line_total;
      r = '0;
      r.line_total = total;
      r.status = STATUS_FAULT;
    end else if (fin) begin
      r.status = STATUS_DONE;
    end
    if (fault || fin) begin
      nxt = ST_IDLE;
      prs_len = '0;
      prs_lines = '0;
    end
    prs_state = nxt;
    return r;
  endfunction

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int idle_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(99, 0);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 4);
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("result %0d: %s mismatch, got %0d expected %0d", results_seen, field, got, want);
    mismatch_count++;
  endtask

  task automatic push_byte(logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  // Build one response for the current mode; a broken one gets a byte replaced,
  // inserted, or the tail cut off.
  task automatic queue_response(int n_lines, int len_lo, int len_hi, bit broken);
    logic [7:0] seq[$];
    int         len;
    int         pos;
    seq.push_back(CH_CR);
    seq.push_back(CH_LF);
    if (special_on && n_lines == 0) n_lines = 1;
    for (int i = 0; i < n_lines; i++) begin
      len = $urandom_range(len_hi, len_lo);
      if (!special_on) seq.push_back(CH_PLUS);
      else if (i > 0 && len == 0) len = 1;
      repeat (len) seq.push_back(8'($urandom_range(CH_HI, CH_LO)));
      seq.push_back(CH_CR);
      seq.push_back(CH_LF);
    end
    if (n_lines > 0) begin
      seq.push_back(CH_CR);
      seq.push_back(CH_LF);
    end
    if ($urandom_range(1, 0) == 1) begin
      seq.push_back(CH_O);
      seq.push_back(CH_K);
    end else begin
      seq.push_back(CH_E);
      seq.push_back(CH_R);
      seq.push_back(CH_R);
      seq.push_back(CH_O);
      seq.push_back(CH_R);
    end
    seq.push_back(CH_CR);
    seq.push_back(CH_LF);
    if (broken) begin
      pos = $urandom_range(seq.size() - 1, 0);
      case ($urandom_range(2, 0))
        0: seq[pos] = 8'($urandom_range(255, 0));
        1: while (seq.size() > pos + 1) void'(seq.pop_back());
        default: seq.insert(pos, 8'($urandom_range(255, 0)));
      endcase
    end
    foreach (seq[k]) push_byte(seq[k]);
  endtask

  // Random mix: mostly well-formed responses, some broken ones, some raw noise.
  task automatic queue_random(int budget);
    int    start;
    int    r;
    int    n_lines;
    int    cap;
    logic [7:0] noise_pick [0:6];
    noise_pick = '{CH_CR, CH_LF, CH_PLUS, CH_O, CH_K, CH_E, CH_R};
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      r = $urandom_range(99, 0);
      n_lines = $urandom_range(99, 0) < 85 ? $urandom_range(4, 0) :
                ($urandom_range(9, 0) < 8 ? $urandom_range(8, 5) : 9);
      cap = $urandom_range(9, 0) == 0 ? 40 : 12;
      if (r < 75) begin
        queue_response(n_lines, 0, cap, 1'b0);
      end else if (r < 90) begin
        queue_response(n_lines, 0, cap, 1'b1);
      end else begin
        repeat ($urandom_range(6, 1)) begin
          if ($urandom_range(1, 0) == 1) push_byte(8'($urandom_range(255, 0)));
          else push_byte(noise_pick[$urandom_range(6, 0)]);
        end
      end
    end
  endtask

  // Wait until every byte has been sent and every result checked, then let the pipe settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || predicted_rsp.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    special_on = m;
  endtask

  // Byte sender: presents queued bytes and predicts each one at its transfer.
  always @(posedge clk) begin : send_bytes
    logic loaded;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
      prs_state = ST_IDLE;
      prs_len = '0;
      prs_lines = '0;
    end else begin
      loaded = in_valid;
      if (in_valid && in_ready) begin
        predicted_rsp.push_back(parse_byte(byte_value));
        loaded = 1'b0;
      end
      if (!loaded) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_bytes.size() != 0) begin
          byte_value <= pending_bytes.pop_front();
          loaded = 1'b1;
          send_gap = idle_len(send_calm);
        end
      end
      if ($urandom_range(149, 0) == 0) send_calm = !send_calm;
      in_valid <= loaded;
    end
  end

  // Result checker: compares each result transfer with the oldest prediction.
  always @(posedge clk) begin : check_results
    arp_result_t seen;
    arp_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen = {status, line_total, char_valid, char_value, char_line, char_col,
                line_done, line_length};
        if (predicted_rsp.size() == 0) begin
          report_mismatch("out_valid with nothing pending", 1, 0);
        end else begin
          want = predicted_rsp.pop_front();
          if (seen.status !== want.status)
            report_mismatch("status", seen.status, want.status);
          if (seen.line_total !== want.line_total)
            report_mismatch("line_total", seen.line_total, want.line_total);
          if (seen.char_valid !== want.char_valid)
            report_mismatch("char_valid", seen.char_valid, want.char_valid);
          if (seen.char_value !== want.char_value)
            report_mismatch("char_value", seen.char_value, want.char_value);
          if (seen.char_line !== want.char_line)
            report_mismatch("char_line", seen.char_line, want.char_line);
          if (seen.char_col !== want.char_col)
            report_mismatch("char_col", seen.char_col, want.char_col);
          if (seen.line_done !== want.line_done)
            report_mismatch("line_done", seen.line_done, want.line_done);
          if (seen.line_length !== want.line_length)
            report_mismatch("line_length", seen.line_length, want.line_length);
        end
        results_seen++;
      end
      // Receiver stalls: a ready cycle may be followed by a stretch of not ready.
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        hold_left = ($urandom_range(3, 0) == 0) ? idle_len(recv_calm) : 0;
      end
      if ($urandom_range(149, 0) == 0) recv_calm = !recv_calm;
    end
  end

  // Watchdog: ends the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence: reset, then phases with the mode register toggled between them.
  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Normal mode: opening bytes, line count and line length limits, then random.
    foreach (opening_bytes[k]) push_byte(opening_bytes[k]);
    queue_response(8, 0, 3, 1'b0);
    queue_response(9, 0, 2, 1'b0);
    queue_response(1, 128, 128, 1'b0);
    queue_random(RANDOM_BYTES);
    wait_drained();

    // Special mode: overlong first line, line count limits, then random.
    write_mode(1'b1);
    queue_response(1, 129, 129, 1'b0);
    queue_response(9, 0, 2, 1'b0);
    queue_response(8, 1, 3, 1'b0);
    queue_random(RANDOM_BYTES);
    wait_drained();

    write_mode(1'b0);
    queue_random(RANDOM_BYTES);
    wait_drained();

    write_mode(1'b1);
    queue_random(RANDOM_BYTES);
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
